>>> hdl/kst_pkg.sv
// Shared types and constants for the keyed set table.
`timescale 1ns / 1ps

package kst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int HDL_W    = 16;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_POP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_PRESENT   = 3'd2,
    STS_FULL      = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_POP,
    ST_DONE
  } state_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [KEY_W-1:0]   key;
    logic [HDL_W-1:0]   handle;
    logic [CNT_W-1:0]   count;
  } result_t;

endpackage

>>> hdl/kst_store.sv
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module kst_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [kst_pkg::IDX_W-1:0]  wr_addr,
  input  logic [kst_pkg::KEY_W-1:0]  wr_key,
  input  logic [kst_pkg::HDL_W-1:0]  wr_handle,
  input  logic [kst_pkg::IDX_W-1:0]  rd_addr,
  output logic [kst_pkg::KEY_W-1:0]  rd_key,
  output logic [kst_pkg::HDL_W-1:0]  rd_handle
);
  import kst_pkg::*;

  logic [KEY_W+HDL_W-1:0] mem [CAPACITY];
  logic [KEY_W+HDL_W-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_handle};
    end
  end

  // Read one entry a cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_key    = rd_data_r[KEY_W+HDL_W-1:HDL_W];
  assign rd_handle = rd_data_r[HDL_W-1:0];

endmodule

>>> hdl/kst_ctrl.sv
// Request sequencer: scans the store one entry a cycle with a shared key compare.
`timescale 1ns / 1ps

module kst_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [1:0]                 req_action,
  input  logic [kst_pkg::KEY_W-1:0]  req_key,
  input  logic [kst_pkg::HDL_W-1:0]  req_handle,
  output logic                       res_valid,
  input  logic                       res_take,
  output kst_pkg::result_t           res,
  output logic                       wr_en,
  output logic [kst_pkg::IDX_W-1:0]  wr_addr,
  output logic [kst_pkg::KEY_W-1:0]  wr_key,
  output logic [kst_pkg::HDL_W-1:0]  wr_handle,
  output logic [kst_pkg::IDX_W-1:0]  rd_addr,
  input  logic [kst_pkg::KEY_W-1:0]  rd_key,
  input  logic [kst_pkg::HDL_W-1:0]  rd_handle
);
  import kst_pkg::*;

  state_t            state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [HDL_W-1:0]  hdl_r, hdl_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  status_t           status_r, status_nxt;
  logic              found_r, found_nxt;
  logic [KEY_W-1:0]  kout_r, kout_nxt;
  logic [HDL_W-1:0]  hout_r, hout_nxt;

  logic              accept;
  logic              hit;
  logic              scan_last;
  logic              is_full;
  logic [CNT_W-1:0]  count_dec;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  tail_idx;

  assign accept    = req_valid && (state_r == ST_IDLE);
  assign hit       = (rd_key == key_r);
  assign count_dec = count_r - 1'b1;
  assign last_idx  = IDX_W'(count_dec);
  assign tail_idx  = IDX_W'(count_r);
  assign scan_last = (CNT_W'(idx_r) == count_dec);
  assign is_full   = (count_r == CNT_W'(CAPACITY));

  assign req_stall = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = '{status: status_r, found: found_r, key: kout_r,
                       handle: hout_r, count: count_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (action_t'(req_action) == ACT_POP) begin
            state_nxt = (count_r == '0) ? ST_DONE : ST_POP;
          end else begin
            state_nxt = (count_r == '0) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = (act_r == ACT_REMOVE) ? ST_MOVE : ST_DONE;
        end else if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MOVE: state_nxt = ST_DONE;
      ST_POP:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    act_nxt    = act_r;
    key_nxt    = key_r;
    hdl_nxt    = hdl_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    kout_nxt   = kout_r;
    hout_nxt   = hout_r;
    wr_en      = 1'b0;
    wr_addr    = tail_idx;
    wr_key     = key_r;
    wr_handle  = hdl_r;
    rd_addr    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt    = action_t'(req_action);
          key_nxt    = req_key;
          hdl_nxt    = req_handle;
          idx_nxt    = '0;
          status_nxt = STS_OK;
          found_nxt  = 1'b0;
          kout_nxt   = '0;
          hout_nxt   = '0;
          if (action_t'(req_action) == ACT_POP) begin
            // Fetch the tail entry, or report an empty table
            rd_addr = last_idx;
            if (count_r == '0) begin
              status_nxt = STS_EMPTY;
            end
          end else if (count_r == '0) begin
            // Nothing to scan: append directly or miss
            if (action_t'(req_action) == ACT_ADD) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_key    = req_key;
              wr_handle = req_handle;
              count_nxt = count_r + 1'b1;
            end else begin
              status_nxt = STS_NOT_FOUND;
            end
          end else begin
            rd_addr = '0;
          end
        end
      end
      ST_SCAN: begin
        rd_addr = idx_r + 1'b1;
        if (hit) begin
          found_nxt = 1'b1;
          kout_nxt  = rd_key;
          hout_nxt  = rd_handle;
          slot_nxt  = idx_r;
          rd_addr   = last_idx;
          if (act_r == ACT_ADD) begin
            status_nxt = STS_PRESENT;
          end
        end else if (scan_last) begin
          if (act_r == ACT_ADD) begin
            if (is_full) begin
              status_nxt = STS_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else begin
            status_nxt = STS_NOT_FOUND;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_MOVE: begin
        // Fill the gap with the tail entry
        wr_en     = 1'b1;
        wr_addr   = slot_r;
        wr_key    = rd_key;
        wr_handle = rd_handle;
        count_nxt = count_dec;
      end
      ST_POP: begin
        kout_nxt  = rd_key;
        hout_nxt  = rd_handle;
        count_nxt = count_dec;
      end
      ST_DONE: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    key_r    <= key_nxt;
    hdl_r    <= hdl_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    kout_r   <= kout_nxt;
    hout_r   <= hout_nxt;
  end

endmodule

>>> hdl/keyed_set_table_top.sv
// Top level of the keyed set table: sequencer, entry store and output register.
`timescale 1ns / 1ps

// A set of up to CAPACITY (16) entries, each a unique 32-bit key with a
// 16-bit handle, kept unordered in the first count slots. Each input beat is
// an add, remove or lookup by key, or a pop, and yields exactly one output
// beat. A single comparator walks the store one entry per cycle, so the time
// for an add, remove or lookup is set by the scan. A hit ends the scan at the
// matching slot. A remove that hits then moves the tail entry into the freed
// slot. A pop reads the tail entry without a scan, and a request on an empty
// table finishes without one. The output beat is registered when the
// sequencer returns to idle and can take the next beat. The input is stalled
// while a request is in progress. A finished result sits in the output
// register, and the next request is taken while it waits. An add of a new
// key to a full table is refused with the full status.
module keyed_set_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_key,
  input  logic [15:0]        in_handle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic               out_found,
  output logic signed [31:0] out_key_out,
  output logic [15:0]        out_handle_out,
  output logic [4:0]         out_count
);
  import kst_pkg::*;

  result_t           res;
  logic              res_valid;
  logic              res_take;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [KEY_W-1:0]  wr_key;
  logic [HDL_W-1:0]  wr_handle;
  logic [IDX_W-1:0]  rd_addr;
  logic [KEY_W-1:0]  rd_key;
  logic [HDL_W-1:0]  rd_handle;

  logic              out_valid_r;
  result_t           out_res_r;

  kst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_stall  (in_stall),
    .req_action (in_action),
    .req_key    (in_key),
    .req_handle (in_handle),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_key     (wr_key),
    .wr_handle  (wr_handle),
    .rd_addr    (rd_addr),
    .rd_key     (rd_key),
    .rd_handle  (rd_handle)
  );

  kst_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_handle (wr_handle),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_handle (rd_handle)
  );

  // Take a result when the output register is free or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  // Hold the output beat until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_found      = out_res_r.found;
  assign out_key_out    = out_res_r.key;
  assign out_handle_out = out_res_r.handle;
  assign out_count      = 5'(out_res_r.count);

endmodule

>>> sim/tb_keyed_set_table_top.sv
// Self-checking testbench for the keyed set table top level.
`timescale 1ns / 1ps

module tb_keyed_set_table_top;
  import kst_pkg::*;

  typedef struct {
    action_t     act;
    logic [31:0] key;
    logic [15:0] hdl;
    int          gap;
  } set_request_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_ADD;
  logic signed [31:0] in_key = '0;
  logic [15:0]        in_handle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic               out_found;
  logic signed [31:0] out_key_out;
  logic [15:0]        out_handle_out;
  logic [4:0]         out_count;

  // Shadow copy of the table contents
  logic [KEY_W-1:0]   shadow_keys [CAPACITY];
  logic [HDL_W-1:0]   shadow_handles [CAPACITY];
  int                 shadow_count = 0;

  set_request_t       request_q[$];
  result_t            table_expect_q[$];
  int                 gap_left = 0;
  int                 in_gap_max = 0;
  int                 stall_left = 0;
  int                 results_seen = 0;
  int                 mismatch_count = 0;

  keyed_set_table_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_handle      (in_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_key_out    (out_key_out),
    .out_handle_out (out_handle_out),
    .out_count      (out_count)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow table and return the result it should give
  function automatic result_t apply_set_op(action_t act, logic [31:0] key,
                                           logic [15:0] hdl);
    result_t r;
    int      i;
    int      slot;
    bit      hit;
    r = '0;
    r.status = STS_OK;
    slot = 0;
    hit = 1'b0;
    if (act == ACT_POP) begin
      if (shadow_count == 0) begin
        r.status = STS_EMPTY;
      end else begin
        shadow_count--;
        r.key = shadow_keys[shadow_count];
        r.handle = shadow_handles[shadow_count];
      end
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        if (!hit && shadow_keys[i] == key) begin
          hit = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        r.found = 1'b1;
        r.key = shadow_keys[slot];
        r.handle = shadow_handles[slot];
      end
      if (act == ACT_ADD) begin
        if (hit) begin
          r.status = STS_PRESENT;
        end else if (shadow_count >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_handles[shadow_count] = hdl;
          shadow_count++;
        end
      end else if (!hit) begin
        r.status = STS_NOT_FOUND;
      end else if (act == ACT_REMOVE) begin
        // fill the gap with the tail entry
        shadow_count--;
        shadow_keys[slot] = shadow_keys[shadow_count];
        shadow_handles[slot] = shadow_handles[shadow_count];
      end
    end
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic queue_request(action_t act, logic [31:0] key, logic [15:0] hdl);
    set_request_t req;
    req.act = act;
    req.key = key;
    req.hdl = hdl;
    req.gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    request_q.push_back(req);
  endtask

  // Driver: present queued requests, predict on each accepted beat
  always @(posedge clk) begin : drive_requests
    set_request_t req;
    logic         next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        table_expect_q.push_back(apply_set_op(action_t'(in_action), in_key, in_handle));
        next_valid = 1'b0;
      end
      if (!next_valid && request_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          req = request_q.pop_front();
          in_action <= req.act;
          in_key <= req.key;
          in_handle <= req.hdl;
          next_valid = 1'b1;
          gap_left = (request_q.size() > 0) ? request_q[0].gap : 0;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: stall at random and check each accepted result beat
  always @(posedge clk) begin : check_results
    result_t exp;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (table_expect_q.size() == 0) begin
          $error("unexpected result beat: status %0d key %h", out_status, out_key_out);
          mismatch_count++;
        end else begin
          exp = table_expect_q.pop_front();
          if (out_status !== exp.status) begin
            $error("status mismatch: expected %0d, got %0d", exp.status, out_status);
            mismatch_count++;
          end
          if (out_found !== exp.found) begin
            $error("found mismatch: expected %0d, got %0d", exp.found, out_found);
            mismatch_count++;
          end
          if (out_key_out !== exp.key) begin
            $error("key_out mismatch: expected %h, got %h", exp.key, out_key_out);
            mismatch_count++;
          end
          if (out_handle_out !== exp.handle) begin
            $error("handle_out mismatch: expected %h, got %h", exp.handle,
                   out_handle_out);
            mismatch_count++;
          end
          if (out_count !== exp.count) begin
            $error("count mismatch: expected %0d, got %0d", exp.count, out_count);
            mismatch_count++;
          end
        end
        results_seen++;
        // no back-pressure in every fourth stretch of results
        stall_left = ((results_seen / 50) % 4 == 0) ? 0 : $urandom_range(0, 16);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Stimulus: directed requests, then random phases
  initial begin : stimulus
    logic [31:0] fill_keys [16];
    logic [31:0] key_pool [24];
    int          phase;
    int          n;
    int          pick;
    int          add_pct;
    int          drop_pct;
    action_t     act;
    logic [31:0] key;

    fill_keys = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                  32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff,
                  32'hffff_0000, 32'h1234_5678, 32'hedcb_a987, 32'h8000_0001,
                  32'h7fff_fffe, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0100};

    // operations on an empty table
    in_gap_max = 3;
    queue_request(ACT_POP, 32'h0, 16'h0);
    queue_request(ACT_LOOKUP, 32'h8000_0000, 16'hffff);
    queue_request(ACT_REMOVE, 32'h7fff_ffff, 16'h0);
    // fill to capacity with extreme keys and handles
    for (n = 0; n < 16; n++) begin
      queue_request(ACT_ADD, fill_keys[n],
                    (n == 0) ? 16'h0000 : (n == 1) ? 16'hffff : 16'(n * 16'h1111));
    end
    // refused add, duplicate add, hit and miss, swap-remove, pop
    queue_request(ACT_ADD, 32'h3333_3333, 16'hbeef);
    queue_request(ACT_ADD, 32'hffff_ffff, 16'h1234);
    queue_request(ACT_LOOKUP, 32'h7fff_ffff, 16'h0);
    queue_request(ACT_REMOVE, 32'h8000_0000, 16'h0);
    queue_request(ACT_LOOKUP, 32'h0000_0100, 16'h0);
    queue_request(ACT_POP, 32'h0, 16'h0);
    queue_request(ACT_LOOKUP, 32'h8000_0000, 16'h0);

    // random phases: keys mostly from a small pool so hits and a full table are common
    for (phase = 0; phase < 15; phase++) begin
      case ($urandom_range(0, 2))
        0: in_gap_max = 0;
        1: in_gap_max = 4;
        default: in_gap_max = 16;
      endcase
      case (phase % 3)
        0: begin add_pct = 60; drop_pct = 80; end
        1: begin add_pct = 35; drop_pct = 65; end
        default: begin add_pct = 20; drop_pct = 70; end
      endcase
      for (n = 0; n < 24; n++) key_pool[n] = $urandom;
      if (phase % 2 == 0) begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0;
        key_pool[3] = 32'hffff_ffff;
      end
      for (n = 0; n < 102; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < add_pct) act = ACT_ADD;
        else if (pick < drop_pct) act = ACT_REMOVE;
        else if (pick < 92) act = ACT_LOOKUP;
        else act = ACT_POP;
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 23)] : $urandom;
        queue_request(act, key, 16'($urandom_range(0, 65535)));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then give the block time to emit anything stray
    while (request_q.size() > 0 || in_valid || table_expect_q.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("keyed_set_table_top test passed");
    end else begin
      $display("keyed_set_table_top test failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #5_000_000;
    $display("keyed_set_table_top test failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/kst_pkg.sv
hdl/kst_store.sv
hdl/kst_ctrl.sv
hdl/keyed_set_table_top.sv
sim/tb_keyed_set_table_top.sv
